FILE: sv/assert_macros.svh
// Assertion macros shared by the ordered queue RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define OQR_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition must never be true outside reset.
`define OQR_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define OQR_ASSERT(label, clk, rst_n, prop, msg)
`define OQR_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

FILE: sv/oqr_pkg.sv
// Package for the ordered queue with remove-by-key: sizes, codes, cell control.
// No dependencies.
package oqr_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int PID_W       = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_DELETE = 1'b1
  } cmd_e;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic             match_en;  // latch compare result
    logic             ins_en;    // tail cell loads key
    logic             del_en;    // cells at/after the hit take neighbor data
    logic [PID_W-1:0] key;
  } cell_ctrl_t;

endpackage

FILE: sv/oqr_if.sv
// Valid/ready channel interfaces for commands and responses.
// Depends on oqr_pkg.
interface oqr_cmd_if;
  import oqr_pkg::*;
  logic             valid;
  logic             ready;
  logic             cmd;
  logic [PID_W-1:0] pid;

  modport source (output valid, output cmd, output pid, input ready);
  modport sink   (input valid, input cmd, input pid, output ready);
endinterface

interface oqr_rsp_if;
  import oqr_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [CNT_W-1:0] count;
  logic [PID_W-1:0] head_pid;

  modport source (output valid, output status, output count, output head_pid, input ready);
  modport sink   (input valid, input status, input count, input head_pid, output ready);
endinterface

FILE: sv/oqr_cell.sv
// One queue slot: holds an identifier, compares it with the key, and
// closes up the gap by taking its neighbor's entry. Depends on oqr_pkg.
module oqr_cell
  import oqr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_ctrl_t       ctrl_i,
  input  logic             live_i,     // slot holds a queued entry
  input  logic             tail_i,     // slot is the first free one
  input  logic             sel_i,      // a match exists closer to the head
  input  logic [PID_W-1:0] nbr_data_i, // entry of the slot behind this one
  output logic             sel_o,
  output logic             match_o,
  output logic [PID_W-1:0] data_o
);

  logic [PID_W-1:0] data_q;
  logic             match_q, match_d;

  assign match_d = live_i && (data_q == ctrl_i.key);
  assign sel_o   = sel_i | match_q;
  assign match_o = match_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (ctrl_i.match_en) begin
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ins_en && tail_i) begin
      data_q <= ctrl_i.key;
    end else if (ctrl_i.del_en && sel_o) begin
      data_q <= nbr_data_i;
    end
  end

endmodule

FILE: sv/ordered_queue_remove_by_key.sv
// Ordered queue of process identifiers with remove-by-key.
// Channels: cmd_i (sink) carries cmd (0 insert at tail, 1 delete first match)
// and pid; rsp_o (source) returns status, count and head_pid for each
// command, exactly one response per command transaction.
// Storage is a row of QUEUE_DEPTH cells; the head sits in cell 0. A delete
// compares all cells in parallel, then every cell at or behind the first
// hit loads its neighbor's entry in the same update.
// Steps: a command is accepted in S_IDLE, compared in S_MATCH, and the
// cells and the response register are updated in S_SHIFT. A new command
// is taken only after the response of the last one is registered; the
// compare and update steps through the cell row set the command pace.
// The response sits in an output register: while the receiver stalls, the
// next command is still accepted and compared, and its update waits until
// the register is free.
// Reset empties the queue (count 0); cell contents are not cleared.
// Depends on oqr_pkg, oqr_if, oqr_cell and assert_macros.svh.
`include "assert_macros.svh"

module ordered_queue_remove_by_key
  import oqr_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  oqr_cmd_if.sink   cmd_i,
  oqr_rsp_if.source rsp_o
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_MATCH = 3'b010,
    S_SHIFT = 3'b100
  } state_e;

  state_e           state_q, state_d;
  logic             cmd_q;
  logic [PID_W-1:0] key_q;
  logic [CNT_W-1:0] count_q, count_d;

  logic             rsp_valid_q;
  status_e          rsp_status_q, status_d;
  logic [CNT_W-1:0] rsp_count_q;
  logic [PID_W-1:0] rsp_head_q, head_d;

  logic             in_fire, load_out, hit, is_del;
  cell_ctrl_t       ctrl;

  logic [QUEUE_DEPTH-1:0] live, tail, match, sel_in, sel_out;
  logic [PID_W-1:0]       cell_data [QUEUE_DEPTH];

  assign cmd_i.ready = (state_q == S_IDLE);
  assign in_fire     = cmd_i.valid && cmd_i.ready;
  assign load_out    = (state_q == S_SHIFT) && (!rsp_valid_q || rsp_o.ready);
  assign is_del      = (cmd_q == CMD_DELETE);
  assign hit         = |match;

  // Cell row
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    assign live[i] = (CNT_W'(i) < count_q);
    assign tail[i] = (CNT_W'(i) == count_q);
    if (i == 0) begin : g_first
      assign sel_in[i] = 1'b0;
    end else begin : g_rest
      assign sel_in[i] = sel_out[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_last
      oqr_cell u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .ctrl_i     (ctrl),
        .live_i     (live[i]),
        .tail_i     (tail[i]),
        .sel_i      (sel_in[i]),
        .nbr_data_i (cell_data[i]),
        .sel_o      (sel_out[i]),
        .match_o    (match[i]),
        .data_o     (cell_data[i])
      );
    end else begin : g_mid
      oqr_cell u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .ctrl_i     (ctrl),
        .live_i     (live[i]),
        .tail_i     (tail[i]),
        .sel_i      (sel_in[i]),
        .nbr_data_i (cell_data[i+1]),
        .sel_o      (sel_out[i]),
        .match_o    (match[i]),
        .data_o     (cell_data[i])
      );
    end
  end

  // Command outcome, evaluated in the update step
  always_comb begin
    status_d = ST_OK;
    count_d  = count_q;
    if (!is_del) begin
      if (count_q == CNT_W'(QUEUE_DEPTH)) begin
        status_d = ST_FULL;
      end else begin
        count_d = count_q + CNT_W'(1);
      end
    end else if (count_q == '0) begin
      status_d = ST_EMPTY;
    end else if (!hit) begin
      status_d = ST_NOT_FOUND;
    end else begin
      count_d = count_q - CNT_W'(1);
    end
  end

  // Head after the update
  always_comb begin
    if (count_d == '0) begin
      head_d = '0;
    end else if (is_del && hit && match[0]) begin
      head_d = cell_data[1];
    end else if (!is_del && count_q == '0) begin
      head_d = key_q;
    end else begin
      head_d = cell_data[0];
    end
  end

  always_comb begin
    ctrl.match_en = (state_q == S_MATCH);
    ctrl.ins_en   = load_out && !is_del && (status_d == ST_OK);
    ctrl.del_en   = load_out && is_del && (status_d == ST_OK);
    ctrl.key      = key_q;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_fire) state_d = S_MATCH;
      S_MATCH: state_d = S_SHIFT;
      S_SHIFT: if (load_out) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        count_q     <= count_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q <= cmd_i.cmd;
      key_q <= cmd_i.pid;
    end
    if (load_out) begin
      rsp_status_q <= status_d;
      rsp_count_q  <= count_d;
      rsp_head_q   <= head_d;
    end
  end

  assign rsp_o.valid    = rsp_valid_q;
  assign rsp_o.status   = rsp_status_q;
  assign rsp_o.count    = rsp_count_q;
  assign rsp_o.head_pid = rsp_head_q;

  `OQR_ASSERT_NEVER(a_count_range, clk_i, rst_ni, count_q > CNT_W'(QUEUE_DEPTH), "count beyond depth")
  `OQR_ASSERT(a_ins_grows, clk_i, rst_ni, (load_out && !is_del && status_d == ST_OK) |=> (count_q == $past(count_q) + CNT_W'(1)), "insert did not grow queue")
  `OQR_ASSERT(a_fail_holds, clk_i, rst_ni, (load_out && status_d != ST_OK) |=> $stable(count_q), "refused command changed count")
  `OQR_ASSERT(a_empty_head, clk_i, rst_ni, (rsp_valid_q && rsp_count_q == '0) |-> (rsp_head_q == '0), "empty queue reports nonzero head")
  `OQR_ASSERT(a_rsp_count, clk_i, rst_ni, (rsp_valid_q && state_q == S_IDLE) |-> (rsp_count_q == count_q), "response count differs from queue count")

endmodule

FILE: tb/ordered_queue_remove_by_key_tb.sv
`timescale 1ns / 1ps
// Testbench for ordered_queue_remove_by_key: directed and random insert/delete
// commands with a queue predictor in a small scoreboard class.
// Depends on oqr_pkg, oqr_if and the block itself.

typedef struct packed {
  oqr_pkg::status_e               status;
  logic [oqr_pkg::CNT_W-1:0]      count;
  logic [oqr_pkg::PID_W-1:0]      head_pid;
} queue_rsp_t;

class queue_scoreboard;
  bit [oqr_pkg::PID_W-1:0] entries[$];   // predicted queue, head at index 0
  queue_rsp_t              expected_q[$];
  int errors;
  int n_checked;
  int n_insert;
  int n_delete;
  int status_seen[4];

  function int pending();
    return expected_q.size();
  endfunction

  // Applies one accepted command to the predicted queue.
  function void note_command(oqr_pkg::cmd_e c, bit [oqr_pkg::PID_W-1:0] key);
    queue_rsp_t r;
    int hit;
    int n;
    r.status = oqr_pkg::ST_OK;
    hit = -1;
    if (c == oqr_pkg::CMD_INSERT) begin
      n_insert++;
      if (entries.size() >= oqr_pkg::QUEUE_DEPTH) r.status = oqr_pkg::ST_FULL;
      else entries.push_back(key);
    end else begin
      n_delete++;
      if (entries.size() == 0) begin
        r.status = oqr_pkg::ST_EMPTY;
      end else begin
        foreach (entries[i]) if (hit < 0 && entries[i] == key) hit = i;
        if (hit < 0) r.status = oqr_pkg::ST_NOT_FOUND;
        else entries.delete(hit);
      end
    end
    n          = entries.size();
    r.count    = n[oqr_pkg::CNT_W-1:0];
    r.head_pid = (entries.size() > 0) ? entries[0] : '0;
    status_seen[r.status]++;
    expected_q.push_back(r);
  endfunction

  task report_mismatch(string msg);
    errors++;
    $display("[%0t] ERROR rsp %0d: %s", $time, n_checked, msg);
  endtask

  task check_response(logic [1:0] st, logic [oqr_pkg::CNT_W-1:0] cnt,
                      logic [oqr_pkg::PID_W-1:0] head);
    queue_rsp_t e;
    n_checked++;
    if (expected_q.size() == 0) begin
      report_mismatch("response with no command outstanding");
      return;
    end
    e = expected_q.pop_front();
    if (st !== e.status)
      report_mismatch($sformatf("status got %0d want %0d", st, e.status));
    if (cnt !== e.count)
      report_mismatch($sformatf("count got %0d want %0d", cnt, e.count));
    if (head !== e.head_pid)
      report_mismatch($sformatf("head_pid got %h want %h", head, e.head_pid));
  endtask
endclass

module ordered_queue_remove_by_key_tb;
  import oqr_pkg::*;

  localparam int LONG_HOLD = 400;
  localparam int N_BLOCKS  = 30;
  localparam int BLOCK_LEN = 60;

  logic clk_i = 1'b0;
  logic rst_ni;

  oqr_cmd_if cmd_ch ();
  oqr_rsp_if rsp_ch ();

  ordered_queue_remove_by_key DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_ch),
    .rsp_o  (rsp_ch)
  );

  queue_scoreboard sb = new();

  bit quiet;           // no idling at all in the closing part
  bit long_hold_req;   // asks the receiver for one long stall
  int tx_idle_pct;     // chance of a sender gap before a command
  int rx_idle_pct;     // per-cycle chance of a receiver stall burst

  always #5 clk_i = ~clk_i;

  initial begin
    rst_ni        <= 1'b0;
    cmd_ch.valid  <= 1'b0;
    cmd_ch.cmd    <= CMD_INSERT;
    cmd_ch.pid    <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Sends one command; returns at the edge where the transaction happens.
  task send_cmd(cmd_e c, bit [PID_W-1:0] key);
    if (!quiet && $urandom_range(0, 99) < tx_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.cmd   <= c;
    cmd_ch.pid   <= key;
    do @(posedge clk_i); while (cmd_ch.ready !== 1'b1);
    sb.note_command(c, key);
  endtask

  task wait_drained();
    cmd_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Response side: checks transactions and drives ready with stall bursts.
  initial begin
    int stall_left;
    stall_left = 0;
    rsp_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        sb.check_response(rsp_ch.status, rsp_ch.count, rsp_ch.head_pid);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && !quiet && $urandom_range(0, 99) < rx_idle_pct) begin
        stall_left = $urandom_range(1, 17);
      end
      if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    bit [PID_W-1:0] key;
    bit             is_ins;
    int             ins_pct;
    int             idx;
    quiet         = 1'b0;
    long_hold_req = 1'b0;
    tx_idle_pct   = 20;
    rx_idle_pct   = 5;
    @(posedge rst_ni);
    repeat (2) @(posedge clk_i);

    // Directed: empty delete, only-entry delete, fill, full insert,
    // miss, duplicate, middle, tail and head removal.
    send_cmd(CMD_DELETE, 16'h1234);
    send_cmd(CMD_INSERT, 16'h0000);
    send_cmd(CMD_DELETE, 16'h0000);
    for (int i = 0; i < QUEUE_DEPTH; i++)
      send_cmd(CMD_INSERT, PID_W'((i == 3 || i == 9) ? 16'hA5A5 :
                                  (i == 15) ? 16'h8000 : i * 16'h1111));
    send_cmd(CMD_INSERT, 16'hFFFF);
    send_cmd(CMD_DELETE, 16'h5A5A);
    send_cmd(CMD_DELETE, 16'hA5A5);
    send_cmd(CMD_DELETE, 16'h7777);
    send_cmd(CMD_DELETE, 16'h8000);
    send_cmd(CMD_DELETE, 16'h0000);

    for (int blk = 0; blk < N_BLOCKS; blk++) begin
      if (blk == 10 || blk == 20 || blk == N_BLOCKS - 3) wait_drained();
      quiet = (blk >= N_BLOCKS - 3);
      if (blk == 5) long_hold_req = 1'b1;
      case ($urandom_range(0, 2))
        0:       ins_pct = 80;  // filling
        1:       ins_pct = 25;  // draining
        default: ins_pct = 50;
      endcase
      case ($urandom_range(0, 2))
        0:       tx_idle_pct = 0;
        1:       tx_idle_pct = 15;
        default: tx_idle_pct = 40;
      endcase
      case ($urandom_range(0, 2))
        0:       rx_idle_pct = 0;
        1:       rx_idle_pct = 3;
        default: rx_idle_pct = 12;
      endcase
      repeat (BLOCK_LEN) begin
        is_ins = ($urandom_range(0, 99) < ins_pct);
        if (!is_ins && sb.entries.size() > 0 && $urandom_range(0, 9) < 7) begin
          idx = $urandom_range(0, sb.entries.size() - 1);
          key = sb.entries[idx];
        end else if ($urandom_range(0, 2) == 0) begin
          // small pool so duplicates are common
          key = PID_W'(16'hC000 | $urandom_range(0, 5));
        end else begin
          key = PID_W'($urandom_range(0, 16'hFFFF));
        end
        send_cmd(cmd_e'(is_ins ? CMD_INSERT : CMD_DELETE), key);
      end
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (sb.pending() != 0) sb.report_mismatch("responses still outstanding at end");

    $display("Covered %0d commands (%0d inserts, %0d deletes), %0d responses checked",
             sb.n_insert + sb.n_delete, sb.n_insert, sb.n_delete, sb.n_checked);
    $display("Status ok %0d, empty %0d, not found %0d, full %0d; long output stall done",
             sb.status_seen[ST_OK], sb.status_seen[ST_EMPTY],
             sb.status_seen[ST_NOT_FOUND], sb.status_seen[ST_FULL]);
    if (sb.errors == 0) begin
      $display("ordered_queue_remove_by_key: match");
    end else begin
      $display("ordered_queue_remove_by_key: mismatch");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Timeout: run did not complete");
    $display("ordered_queue_remove_by_key: mismatch");
    $finish;
  end

endmodule
